### design/tlpg_pkg.sv
package tlpg_pkg;

	localparam int SCREEN_WIDTH  = 800;
	localparam int SCREEN_HEIGHT = 480;
	localparam int NUM_LAYERS    = 8;

	localparam int COORD_W = 12;
	localparam int SPAN_W  = 12;
	localparam int ERR_W   = 14;
	localparam int HALF_W  = 5;
	localparam int BRUSH_W = 6;
	localparam int THICK_W = 6;
	localparam int COLOR_W = 32;
	localparam int LAYER_W = 3;
	localparam int ADDR_W  = 19;
	localparam int PIX_W   = COORD_W + 1;
	localparam int SCR_W   = 11;
	localparam int PROD_W  = 22;
	localparam int QDEPTH  = 2;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                      is_start;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] goal_x;
		logic signed [COORD_W-1:0] goal_y;
		logic [SPAN_W-1:0]         span_x;
		logic [SPAN_W-1:0]         span_y;
		logic                      dir_x_neg;
		logic                      dir_y_neg;
		logic signed [ERR_W-1:0]   err;
		logic [HALF_W-1:0]         half;
		logic [COLOR_W-1:0]        color;
		logic [LAYER_W-1:0]        layer;
	} entry_t;

endpackage

### design/tlpg_front.sv
module tlpg_front
	import tlpg_pkg::*;
(
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [THICK_W-1:0]        thickness,
	input  logic [COLOR_W-1:0]        draw_color,
	input  logic [LAYER_W-1:0]        layer_sel,
	output entry_t                    entry
);

	logic signed [PIX_W-1:0] dx;
	logic signed [PIX_W-1:0] dy;
	logic [SPAN_W-1:0]       sx;
	logic [SPAN_W-1:0]       sy;

	always_comb begin
		dx = PIX_W'(end_x) - PIX_W'(start_x);
		dy = PIX_W'(end_y) - PIX_W'(start_y);
		sx = dx[PIX_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
		sy = dy[PIX_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);

		entry.is_start  = (cmd_t'(cmd) == CMD_START);
		entry.pos_x     = start_x;
		entry.pos_y     = start_y;
		entry.goal_x    = end_x;
		entry.goal_y    = end_y;
		entry.span_x    = sx;
		entry.span_y    = sy;
		entry.dir_x_neg = !(start_x < end_x);
		entry.dir_y_neg = !(start_y < end_y);
		entry.err       = $signed(ERR_W'(sx)) - $signed(ERR_W'(sy));
		entry.half      = thickness[THICK_W-1:1];
		entry.color     = draw_color;
		entry.layer     = layer_sel;
	end

endmodule

### design/tlpg_queue.sv
module tlpg_queue
	import tlpg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   nonempty,
	output entry_t head
);

	entry_t     mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(QDEPTH));
	assign nonempty = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/tlpg_back.sv
module tlpg_back
	import tlpg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  entry_t             q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               write_valid,
	output logic [ADDR_W-1:0]  pixel_addr,
	output logic [COLOR_W-1:0] pixel_color,
	output logic [LAYER_W-1:0] target_layer,
	output logic               last
);

	logic                      active_q;
	logic signed [COORD_W-1:0] point_x_q;
	logic signed [COORD_W-1:0] point_y_q;
	logic signed [COORD_W-1:0] goal_x_q;
	logic signed [COORD_W-1:0] goal_y_q;
	logic [SPAN_W-1:0]         span_x_q;
	logic [SPAN_W-1:0]         span_y_q;
	logic                      dir_x_neg_q;
	logic                      dir_y_neg_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [HALF_W-1:0]         half_q;
	logic [BRUSH_W-1:0]        bi_q;
	logic [BRUSH_W-1:0]        bj_q;
	logic [COLOR_W-1:0]        color_q;
	logic [LAYER_W-1:0]        layer_q;

	logic                      out_valid_q;
	logic                      wv_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [COLOR_W-1:0]        ocolor_q;
	logic [LAYER_W-1:0]        olayer_q;
	logic                      last_q;

	logic                      slot_free;
	logic                      emit;
	logic                      load;
	logic [BRUSH_W-1:0]        top;
	logic signed [PIX_W-1:0]   px;
	logic signed [PIX_W-1:0]   py;
	logic                      on;
	logic [PROD_W-1:0]         prod;
	logic                      at_goal;
	logic                      bj_end;
	logic                      bi_end;
	logic signed [ERR_W:0]     e2;
	logic                      mv_x;
	logic                      mv_y;
	logic signed [ERR_W-1:0]   err_next;

	assign slot_free = !out_valid_q || !out_stall;
	assign q_pop     = q_nonempty && slot_free;
	assign load      = q_pop && q_head.is_start;
	assign emit      = q_pop && !q_head.is_start && active_q;

	always_comb begin
		top = BRUSH_W'({half_q, 1'b0});
		px  = PIX_W'(point_x_q) + $signed(PIX_W'(bi_q)) - $signed(PIX_W'(half_q));
		py  = PIX_W'(point_y_q) + $signed(PIX_W'(bj_q)) - $signed(PIX_W'(half_q));
		on  = !px[PIX_W-1] && (px < $signed(PIX_W'(SCREEN_WIDTH)))
			&& !py[PIX_W-1] && (py < $signed(PIX_W'(SCREEN_HEIGHT)))
			&& ({1'b0, layer_q} < (LAYER_W + 1)'(NUM_LAYERS));
		prod = PROD_W'(py[SCR_W-1:0]) * PROD_W'(SCREEN_WIDTH) + PROD_W'(px[SCR_W-1:0]);
		at_goal = (point_x_q == goal_x_q) && (point_y_q == goal_y_q);
		bj_end  = (bj_q == top);
		bi_end  = (bi_q == top);
		e2   = {err_q, 1'b0};
		mv_x = e2 > -$signed((ERR_W + 1)'(span_y_q));
		mv_y = e2 < $signed((ERR_W + 1)'(span_x_q));
		err_next = err_q - (mv_x ? $signed(ERR_W'(span_y_q)) : '0)
			+ (mv_y ? $signed(ERR_W'(span_x_q)) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			point_x_q   <= '0;
			point_y_q   <= '0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			span_x_q    <= '0;
			span_y_q    <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			err_q       <= '0;
			half_q      <= '0;
			bi_q        <= '0;
			bj_q        <= '0;
			color_q     <= '0;
			layer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q    <= 1'b1;
				point_x_q   <= q_head.pos_x;
				point_y_q   <= q_head.pos_y;
				goal_x_q    <= q_head.goal_x;
				goal_y_q    <= q_head.goal_y;
				span_x_q    <= q_head.span_x;
				span_y_q    <= q_head.span_y;
				dir_x_neg_q <= q_head.dir_x_neg;
				dir_y_neg_q <= q_head.dir_y_neg;
				err_q       <= q_head.err;
				half_q      <= q_head.half;
				bi_q        <= '0;
				bj_q        <= '0;
				color_q     <= q_head.color;
				layer_q     <= q_head.layer;
			end else if (emit) begin
				if (!bj_end) begin
					bj_q <= bj_q + 1'b1;
				end else begin
					bj_q <= '0;
					if (!bi_end) begin
						bi_q <= bi_q + 1'b1;
					end else begin
						bi_q <= '0;
						if (at_goal) begin
							active_q <= 1'b0;
						end else begin
							err_q <= err_next;
							if (mv_x) begin
								point_x_q <= dir_x_neg_q ? point_x_q - 1'b1 : point_x_q + 1'b1;
							end
							if (mv_y) begin
								point_y_q <= dir_y_neg_q ? point_y_q - 1'b1 : point_y_q + 1'b1;
							end
						end
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			wv_q     <= on;
			addr_q   <= on ? prod[ADDR_W-1:0] : '0;
			ocolor_q <= color_q;
			olayer_q <= layer_q;
			last_q   <= at_goal && bi_end && bj_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_valid  = wv_q;
	assign pixel_addr   = addr_q;
	assign pixel_color  = ocolor_q;
	assign target_layer = olayer_q;
	assign last         = last_q;

endmodule

### design/thick_line_pixel_generator_top.sv
// Thick line pixel generator. A start word (cmd 0) loads the endpoints, brush
// thickness, color and layer and yields no output; each step word (cmd 1) then
// yields one brush pixel, a (2h+1) x (2h+1) square per line point with
// h = thickness/2, until the word with last set; steps while idle are dropped.
// One pixel leaves per clock while out_stall is low and step words are waiting;
// each step word passes through the two-word command queue and the output
// register. A start word abandons any line in progress. Off-screen pixels
// come out with write_valid low and pixel_addr zero.
module thick_line_pixel_generator_top
	import tlpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [THICK_W-1:0]        thickness,
	input  logic [COLOR_W-1:0]        draw_color,
	input  logic [LAYER_W-1:0]        layer_sel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      write_valid,
	output logic [ADDR_W-1:0]         pixel_addr,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic [LAYER_W-1:0]        target_layer,
	output logic                      last
);

	entry_t entry;
	entry_t head;
	logic   full;
	logic   nonempty;
	logic   pop;

	assign in_stall = full;

	tlpg_front u_front (
		.cmd        (cmd),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.thickness  (thickness),
		.draw_color (draw_color),
		.layer_sel  (layer_sel),
		.entry      (entry)
	);

	tlpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !full),
		.push_entry (entry),
		.full       (full),
		.pop        (pop),
		.nonempty   (nonempty),
		.head       (head)
	);

	tlpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (nonempty),
		.q_head       (head),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_valid  (write_valid),
		.pixel_addr   (pixel_addr),
		.pixel_color  (pixel_color),
		.target_layer (target_layer),
		.last         (last)
	);

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import tlpg_pkg::*;

	localparam int ITEMS     = 1750;
	localparam int CALM_TAIL = 250;
	localparam int DRAIN     = 16;
	localparam int LIMIT_NS  = 5000000;

	typedef struct packed {
		cmd_t                      op;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic [THICK_W-1:0]        thick;
		logic [COLOR_W-1:0]        color;
		logic [LAYER_W-1:0]        layer;
	} word_t;

	typedef struct packed {
		logic               wr;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic [LAYER_W-1:0] layer;
		logic               last;
	} pixel_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic                      cmd        = 1'b0;
	logic signed [COORD_W-1:0] start_x    = '0;
	logic signed [COORD_W-1:0] start_y    = '0;
	logic signed [COORD_W-1:0] end_x      = '0;
	logic signed [COORD_W-1:0] end_y      = '0;
	logic [THICK_W-1:0]        thickness  = '0;
	logic [COLOR_W-1:0]        draw_color = '0;
	logic [LAYER_W-1:0]        layer_sel  = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic                      write_valid;
	logic [ADDR_W-1:0]         pixel_addr;
	logic [COLOR_W-1:0]        pixel_color;
	logic [LAYER_W-1:0]        target_layer;
	logic                      last;

	word_t  word_q[$];
	pixel_t pixel_q[$];
	word_t  cur;
	int     errors    = 0;
	int     gap_left  = 0;
	int     gap_rate  = 1;
	int     hold_left = 0;
	int     hold_rate = 1;

	logic                      drawing = 1'b0;
	logic signed [COORD_W-1:0] pos_x   = '0;
	logic signed [COORD_W-1:0] pos_y   = '0;
	logic signed [COORD_W-1:0] aim_x   = '0;
	logic signed [COORD_W-1:0] aim_y   = '0;
	logic [SPAN_W-1:0]         run_x   = '0;
	logic [SPAN_W-1:0]         run_y   = '0;
	logic                      back_x  = 1'b0;
	logic                      back_y  = 1'b0;
	logic signed [ERR_W-1:0]   err     = '0;
	logic [HALF_W-1:0]         half    = '0;
	logic [BRUSH_W-1:0]        col_i   = '0;
	logic [BRUSH_W-1:0]        row_j   = '0;
	logic [COLOR_W-1:0]        ink     = '0;
	logic [LAYER_W-1:0]        plane   = '0;

	thick_line_pixel_generator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.thickness    (thickness),
		.draw_color   (draw_color),
		.layer_sel    (layer_sel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_valid  (write_valid),
		.pixel_addr   (pixel_addr),
		.pixel_color  (pixel_color),
		.target_layer (target_layer),
		.last         (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= 100)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic trace_brush(input word_t w);
		int     sx, sy, ex, ey, px, py, top, e2;
		logic   at_goal, on;
		pixel_t p;
		if (w.op == CMD_START) begin
			sx = int'($signed(w.sx));
			sy = int'($signed(w.sy));
			ex = int'($signed(w.ex));
			ey = int'($signed(w.ey));
			pos_x = w.sx;
			pos_y = w.sy;
			aim_x = w.ex;
			aim_y = w.ey;
			run_x = SPAN_W'(ex > sx ? ex - sx : sx - ex);
			run_y = SPAN_W'(ey > sy ? ey - sy : sy - ey);
			back_x = !(sx < ex);
			back_y = !(sy < ey);
			err = ERR_W'(int'(run_x) - int'(run_y));
			half = HALF_W'(w.thick >> 1);
			col_i = '0;
			row_j = '0;
			ink = w.color;
			plane = w.layer;
			drawing = 1'b1;
		end else if (drawing) begin
			top = 2 * int'(half);
			px = int'(pos_x) + int'(col_i) - int'(half);
			py = int'(pos_y) + int'(row_j) - int'(half);
			at_goal = (pos_x == aim_x) && (pos_y == aim_y);
			on = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT
				&& int'(plane) < NUM_LAYERS;
			p.wr = on;
			p.addr = on ? ADDR_W'(py * SCREEN_WIDTH + px) : '0;
			p.color = ink;
			p.layer = plane;
			p.last = at_goal && int'(col_i) == top && int'(row_j) == top;
			pixel_q.insert(pixel_q.size(), p);
			if (int'(row_j) < top)
				row_j++;
			else begin
				row_j = '0;
				if (int'(col_i) < top)
					col_i++;
				else begin
					col_i = '0;
					if (at_goal)
						drawing = 1'b0;
					else begin
						e2 = 2 * int'(err);
						if (e2 > -int'(run_y)) begin
							err = ERR_W'(int'(err) - int'(run_y));
							pos_x = COORD_W'(int'(pos_x) + (back_x ? -1 : 1));
						end
						if (e2 < int'(run_x)) begin
							err = ERR_W'(int'(err) + int'(run_x));
							pos_y = COORD_W'(int'(pos_y) + (back_y ? -1 : 1));
						end
					end
				end
			end
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixel_q.size() == 0)
			report($sformatf("pixel with none due, addr %0d", pixel_addr));
		else begin
			want = pixel_q.pop_front();
			if (write_valid !== want.wr)
				report($sformatf("write_valid %b, want %b", write_valid, want.wr));
			if (pixel_addr !== want.addr)
				report($sformatf("pixel_addr %0d, want %0d", pixel_addr, want.addr));
			if (pixel_color !== want.color)
				report($sformatf("pixel_color %h, want %h", pixel_color, want.color));
			if (target_layer !== want.layer)
				report($sformatf("target_layer %0d, want %0d", target_layer, want.layer));
			if (last !== want.last)
				report($sformatf("last %b, want %b", last, want.last));
		end
	endtask

	task automatic queue_line(input int sx, sy, ex, ey, thick,
			input logic [COLOR_W-1:0] color, input int layer);
		word_t w;
		w.op = CMD_START;
		w.sx = COORD_W'(sx);
		w.sy = COORD_W'(sy);
		w.ex = COORD_W'(ex);
		w.ey = COORD_W'(ey);
		w.thick = THICK_W'(thick);
		w.color = color;
		w.layer = LAYER_W'(layer);
		word_q.insert(word_q.size(), w);
	endtask

	task automatic queue_steps(input int n);
		word_t w;
		repeat (n) begin
			w.op = CMD_STEP;
			w.sx = COORD_W'($urandom);
			w.sy = COORD_W'($urandom);
			w.ex = COORD_W'($urandom);
			w.ey = COORD_W'($urandom);
			w.thick = THICK_W'($urandom);
			w.color = $urandom;
			w.layer = LAYER_W'($urandom);
			word_q.insert(word_q.size(), w);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else begin
			if (in_valid && !in_stall)
				trace_brush(cur);
			if (!in_valid || !in_stall) begin
				if ($urandom_range(0, 99) == 0)
					gap_rate = $urandom_range(0, 2);
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_q.size() > CALM_TAIL && gap_rate != 0
						&& $urandom_range(0, gap_rate == 1 ? 15 : 3) == 0) begin
					gap_left = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (word_q.size() != 0) begin
					cur = word_q.pop_front();
					in_valid <= 1'b1;
					cmd <= cur.op;
					start_x <= cur.sx;
					start_y <= cur.sy;
					end_x <= cur.ex;
					end_y <= cur.ey;
					thickness <= cur.thick;
					draw_color <= cur.color;
					layer_sel <= cur.layer;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall)
				check_pixel();
			if ($urandom_range(0, 199) == 0)
				hold_rate = $urandom_range(0, 2);
			if (hold_left > 0)
				hold_left--;
			else if (word_q.size() > CALM_TAIL && hold_rate != 0
					&& $urandom_range(0, hold_rate == 1 ? 15 : 3) == 0)
				hold_left = $urandom_range(1, 19);
			out_stall <= (hold_left > 0);
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("tb: errors");
		$finish;
	end

	initial begin
		int sx, sy, dx, dy, ax, ay, thick, h, full, n, count, pick;

		// step while idle, single-pixel line, screen corner clip, coordinate extremes
		queue_steps(1);
		queue_line(0, 0, 0, 0, 0, 32'h0000_0000, 0);
		queue_steps(2);
		queue_line(799, 479, 800, 480, 1, 32'hFFFF_FFFF, 7);
		queue_steps(2);
		queue_line(-2048, -2048, 2047, 2047, 63, 32'hA5A5_A5A5, 5);
		queue_steps(3);
		queue_line(2047, 2047, -2048, -2048, 62, 32'h5A5A_5A5A, 2);
		queue_steps(1);
		queue_line(0, 0, 0, 0, 3, 32'h1234_5678, 3);
		queue_steps(9);
		queue_line(-1, 2, 1, 0, 0, 32'h8765_4321, 4);
		queue_steps(3);

		count = 0;
		while (count < ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5 || pick == 9) begin
				sx = int'($urandom_range(0, 860)) - 30;
				sy = int'($urandom_range(0, 540)) - 30;
				if (pick == 9) begin
					dx = int'($urandom_range(0, 60)) - 30;
					dy = int'($urandom_range(0, 60)) - 30;
					thick = $urandom_range(0, 1);
				end else begin
					dx = int'($urandom_range(0, 10)) - 5;
					dy = int'($urandom_range(0, 10)) - 5;
					thick = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
						: $urandom_range(0, 5);
				end
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				h = thick / 2;
				full = ((ax > ay ? ax : ay) + 1) * (2 * h + 1) * (2 * h + 1);
				queue_line(sx, sy, sx + dx, sy + dy, thick, $urandom, $urandom_range(0, 7));
				if (full <= 150 && $urandom_range(0, 3) != 0)
					n = full + $urandom_range(0, 2);
				else
					n = $urandom_range(0, full < 150 ? full : 150);
				queue_steps(n);
				count += 1 + (n < full ? n : full);
			end else if (pick <= 7) begin
				n = $urandom_range(0, 30);
				queue_line(int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048,
					$urandom_range(0, 63), $urandom, $urandom_range(0, 7));
				queue_steps(n);
				count += 1 + n;
			end else
				queue_steps($urandom_range(1, 3));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### files.f
design/tlpg_pkg.sv
design/tlpg_front.sv
design/tlpg_queue.sv
design/tlpg_back.sv
design/thick_line_pixel_generator_top.sv
bench/tb.sv
